// ----- hw/rtl/dtt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtt_pkg: shared types and constants
// Widths and the payload carried between the difficulty-to-target stages.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int unsigned DIFF_W   = 64;
  localparam int unsigned TGT_W    = 256;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned MANT_W   = 23;
  localparam logic [31:0] DIFF1_RESET = 32'h1d00ffff;

  // One pipeline slot. The numerator is shifted out at the top while
  // quotient bits are shifted in at the bottom of the same register.
  typedef struct packed {
    logic              valid;
    logic [DIFF_W-1:0] divisor;
    logic [DIFF_W-1:0] rem;
    logic [TGT_W-1:0]  nq;
  } dtt_stage_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dtt_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtt_decode: compact target decode stage
// Expands the compact difficulty-one target into 256 bits and registers it
// together with the incoming difficulty.
// ----------------------------------------------------------------------------
module dtt_decode
  import dtt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [DIFF_W-1:0] difficulty,
  input  wire logic [31:0]       compact,
  output dtt_stage_t             stage_o
);

  logic [7:0]       size;
  logic [7:0]       off;
  logic [TGT_W-1:0] mant;
  logic [TGT_W-1:0] base;
  dtt_stage_t       stage_r;

  always_comb begin
    size = compact[31:24];
    off  = size - 8'd3;
    mant = {{(TGT_W-MANT_W){1'b0}}, compact[MANT_W-1:0]};
    if (size <= 8'd3) begin
      base = mant >> {2'd3 - size[1:0], 3'b000};
    end else if (off >= 8'd32) begin
      base = '0;
    end else begin
      base = mant << {off[4:0], 3'b000};
    end
  end

  // Only the valid bit is reset; the data fields simply follow it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r.valid <= in_valid;
    end
    if (en) begin
      stage_r.divisor <= difficulty;
      stage_r.rem     <= '0;
      stage_r.nq      <= base;
    end
  end

  assign stage_o = stage_r;

endmodule
`default_nettype wire

// ----- hw/rtl/dtt_div_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtt_div_stage: one restoring division step
// Brings down one numerator bit, compares against the divisor and produces
// one quotient bit.
// ----------------------------------------------------------------------------
module dtt_div_stage
  import dtt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  dtt_stage_t stage_i,
  output dtt_stage_t stage_o
);

  logic [DIFF_W:0]   shifted;
  logic              take;
  logic [DIFF_W-1:0] rem_nxt;
  dtt_stage_t        stage_r;

  always_comb begin
    shifted = {stage_i.rem, stage_i.nq[TGT_W-1]};
    // A carry out of the remainder means it already exceeds any divisor.
    take    = shifted[DIFF_W] || (shifted[DIFF_W-1:0] >= stage_i.divisor);
    rem_nxt = take ? (shifted[DIFF_W-1:0] - stage_i.divisor) : shifted[DIFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r.valid <= stage_i.valid;
    end
    if (en) begin
      stage_r.divisor <= stage_i.divisor;
      stage_r.rem     <= rem_nxt;
      stage_r.nq      <= {stage_i.nq[TGT_W-2:0], take};
    end
  end

  assign stage_o = stage_r;

endmodule
`default_nettype wire

// ----- hw/rtl/difficulty_to_target_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// difficulty_to_target_unit: share difficulty to 256-bit target converter
// Computes floor(diff1_target / difficulty) with a fully pipelined divider.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall / in_difficulty) takes one
//   transaction per cycle while in_stall is low. Each produces exactly one
//   result transaction on out_valid / out_stall / out_target_w0..w3, in order.
//   One decode stage expands the compact difficulty-one target, followed by
//   256 restoring division stages, one quotient bit each. Throughput is one
//   transaction per cycle while no finished result is held by out_stall.
//   A difficulty of zero naturally yields all ones: every step subtracts
//   zero and sets its quotient bit.
//   The configuration channel (cfg_valid / cfg_ready / cfg_diff1_compact) is
//   always ready. Write it only while the pipeline is empty; items already
//   inside use the value they saw at entry.
//   Reset (rst_n low, synchronous) empties the pipeline and restores the
//   difficulty-one target to 0x1d00ffff.
//   When the receiver asserts out_stall with a result waiting, the entire
//   pipeline freezes and in_stall rises; no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module difficulty_to_target_unit
  import dtt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [DIFF_W-1:0] in_difficulty,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [WORD_W-1:0]      out_target_w0,
  output logic [WORD_W-1:0]      out_target_w1,
  output logic [WORD_W-1:0]      out_target_w2,
  output logic [WORD_W-1:0]      out_target_w3,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [31:0]       cfg_diff1_compact
);

  logic        en;
  logic [31:0] diff1_r;
  dtt_stage_t  pipe [TGT_W+1];

  // The whole pipeline moves together unless a finished result is blocked.
  assign en        = !(pipe[TGT_W].valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff1_r <= DIFF1_RESET;
    end else if (cfg_valid) begin
      diff1_r <= cfg_diff1_compact;
    end
  end

  dtt_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .difficulty (in_difficulty),
    .compact    (diff1_r),
    .stage_o    (pipe[0])
  );

  for (genvar g = 0; g < TGT_W; g++) begin : g_div
    dtt_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .stage_i (pipe[g]),
      .stage_o (pipe[g+1])
    );
  end

  // After the last step the shift register holds only quotient bits.
  assign out_valid     = pipe[TGT_W].valid;
  assign out_target_w0 = pipe[TGT_W].nq[WORD_W-1:0];
  assign out_target_w1 = pipe[TGT_W].nq[2*WORD_W-1:WORD_W];
  assign out_target_w2 = pipe[TGT_W].nq[3*WORD_W-1:2*WORD_W];
  assign out_target_w3 = pipe[TGT_W].nq[4*WORD_W-1:3*WORD_W];

endmodule
`default_nettype wire

// ----- bench/dtt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_checker: target prediction and result comparison
// Watches the input, result and configuration channels, predicts each target
// from the difficulty and the difficulty-one setting, and compares in order.
// ----------------------------------------------------------------------------
module dtt_checker
  import dtt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [DIFF_W-1:0] in_difficulty,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [WORD_W-1:0] out_target_w0,
  input  logic [WORD_W-1:0] out_target_w1,
  input  logic [WORD_W-1:0] out_target_w2,
  input  logic [WORD_W-1:0] out_target_w3,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [31:0]       cfg_diff1_compact,
  output int                fail_count,
  output int                pending_targets
);

  logic [31:0]      diff1_setting;
  logic [TGT_W-1:0] target_queue[$];

  assign pending_targets = target_queue.size();

  // Expands the compact form; the sign bit is ignored and overflow is cut.
  function automatic logic [TGT_W-1:0] expand_compact(input logic [31:0] c);
    logic [7:0]       size;
    logic [TGT_W-1:0] mant;
    mant = TGT_W'(c[22:0]);
    size = c[31:24];
    if (size <= 8'd3) return mant >> (8 * (3 - size));
    if (size >= 8'd35) return '0;
    return mant << (8 * (size - 3));
  endfunction

  function automatic logic [TGT_W-1:0] share_target(input logic [31:0] c,
                                                   input logic [DIFF_W-1:0] d);
    if (d == '0) return '1;
    return expand_compact(c) / {192'd0, d};
  endfunction

  always @(posedge clk) begin
    logic [TGT_W-1:0] got;
    logic [TGT_W-1:0] want;
    if (!rst_n) begin
      diff1_setting <= DIFF1_RESET;
      fail_count    <= 0;
      target_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) diff1_setting <= cfg_diff1_compact;
      if (out_valid && !out_stall) begin
        got = {out_target_w3, out_target_w2, out_target_w1, out_target_w0};
        if (target_queue.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = target_queue.pop_front();
          if (got != want) begin
            $display("%0t: target mismatch expected %h actual %h", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        target_queue.push_back(share_target(diff1_setting, in_difficulty));
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: difficulty-to-target regression
// Runs directed and random difficulties through several difficulty-one
// settings with random gaps and stalls; the checker compares every target.
// ----------------------------------------------------------------------------
module tb;
  import dtt_pkg::*;

  localparam int PIPE_DEPTH  = 257;
  localparam int STALL_LIMIT = 20000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [DIFF_W-1:0] in_difficulty = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_target_w0, out_target_w1, out_target_w2, out_target_w3;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [31:0]       cfg_diff1_compact = '0;
  int                fail_count;
  int                pending_targets;
  int                idle_cycles;
  bit                stimulus_done = 1'b0;

  // Square wave: 6 ns high, 6 ns low.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  difficulty_to_target_unit dut (.*);

  dtt_checker checker_i (.*);

  // The receiver draws a stall length for each result it takes. Some phases
  // run with no back pressure at all so the pipeline streams at full rate.
  bit quiet_receiver = 1'b0;
  int receiver_wait  = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (receiver_wait > 0) begin
        receiver_wait <= receiver_wait - 1;
        out_stall     <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid && !out_stall)
          receiver_wait <= quiet_receiver ? 0 : $urandom_range(0, 6);
      end
    end
  end

  // The watchdog counts cycles in which no transaction is accepted on
  // either channel and gives up once that limit is reached.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Sends one difficulty after a random gap (none if no_gap) and holds it until accepted.
  // in_valid stays high after acceptance so that a back-to-back transaction
  // follows without a gap; a gap or any other step lowers it first.
  task automatic send_difficulty(input logic [DIFF_W-1:0] d, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_difficulty <= d;
    do @(posedge clk); while (in_stall);
  endtask

  // Configuration is written only with the pipeline drained.
  task automatic write_diff1(input logic [31:0] c);
    in_valid <= 1'b0;
    while (pending_targets != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid         <= 1'b1;
    cfg_diff1_compact <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random difficulty with a spread of magnitudes, so that quotients range
  // from the full target width down to zero.
  function automatic logic [DIFF_W-1:0] random_difficulty();
    logic [DIFF_W-1:0] d;
    d = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: d = d >> $urandom_range(0, 63);
      1: d = DIFF_W'(1) << $urandom_range(0, 63);
      2: d = DIFF_W'($urandom_range(0, 16));
      3: d = '1 - DIFF_W'($urandom_range(0, 3));
      default: ;
    endcase
    return d;
  endfunction

  initial begin
    logic [31:0] settings[10];
    logic [DIFF_W-1:0] directed[$];
    settings = '{32'h1d00ffff, 32'h1f00ffff, 32'h1f07ffff, 32'hffffffff,
                 32'h00000000, 32'h02ffffff, 32'h2300ffff, 32'h227fffff,
                 32'h03800001, 32'h1d00ffff};
    directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'hffffffffffffffff,
                 64'hfffffffffffffffe, 64'h8000000000000000, 64'h7fffffffffffffff,
                 64'd65535, 64'd65536, 64'h00000000ffffffff, 64'h5555555555555555,
                 64'haaaaaaaaaaaaaaaa, 64'd1000, 64'd7};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed difficulties under the reset setting, back to back.
    foreach (directed[i]) send_difficulty(directed[i], 1'b1);

    // Each setting, including the sign-flag, overflow and small-size cases,
    // gets its directed set plus a random phase.
    foreach (settings[s]) begin
      write_diff1(settings[s]);
      quiet_receiver = (s % 3 == 2);
      foreach (directed[i]) send_difficulty(directed[i], s % 2 == 0);
      repeat (160) send_difficulty(random_difficulty(), quiet_receiver);
    end

    // Random compact values fill in the rest.
    repeat (4) begin
      write_diff1($urandom);
      quiet_receiver = 1'b0;
      repeat (20) send_difficulty(random_difficulty(), 1'b0);
    end

    in_valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Verdict once all targets have come back and the pipeline has settled.
  initial begin
    wait (stimulus_done);
    while (pending_targets != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- difficulty_to_target_unit.f -----
hw/rtl/dtt_pkg.sv
hw/rtl/dtt_decode.sv
hw/rtl/dtt_div_stage.sv
hw/rtl/difficulty_to_target_unit.sv
bench/dtt_checker.sv
bench/tb.sv
